// File: rtl/dosr_pkg.sv
// Package for the DHCP option scan and reply block.
// Holds transaction types, register indexes, protocol constants and reset values.
// No dependencies.
package dosr_pkg;

    localparam int OPTION_AREA_BYTES_DEF = 312;

    localparam logic       ACT_HEADER = 1'b0;
    localparam logic       ACT_OPTION = 1'b1;

    localparam logic [7:0] BOOTP_REQUEST = 8'd1;
    localparam logic [7:0] OPT_PAD       = 8'd0;
    localparam logic [7:0] OPT_MSG_TYPE  = 8'd53;
    localparam logic [7:0] OPT_END       = 8'hFF;
    localparam logic [7:0] MSG_DISCOVER  = 8'd1;
    localparam logic [7:0] MSG_REQUEST   = 8'd3;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_OFFER = 2'd1;
    localparam logic [1:0] KIND_ACK   = 2'd2;

    localparam int         ADDR_W         = 4;
    localparam logic [1:0] REG_SERVER     = 2'd0;
    localparam logic [1:0] REG_POOL_FIRST = 2'd1;
    localparam logic [1:0] REG_POOL_LAST  = 2'd2;

    localparam logic [31:0] NET_MASK        = 32'h00FF_FFFF;
    localparam logic [7:0]  POOL_FIRST_RST  = 8'd120;
    localparam logic [7:0]  POOL_LAST_RST   = 8'd150;
    localparam logic [8:0]  HOST_SAT        = 9'd256;

    typedef struct packed {
        logic        action;
        logic [7:0]  op_code;
        logic [31:0] client_ip;
        logic [7:0]  option_byte;
        logic        last_byte;
    } req_t;

    typedef struct packed {
        logic [1:0]  reply_kind;
        logic [31:0] your_address;
        logic [31:0] reply_server;
    } rsp_t;

    typedef struct packed {
        logic        found;
        logic [7:0]  found_type;
        logic [7:0]  held_op;
        logic [31:0] held_client;
    } scan_t;

endpackage

// File: rtl/dhcp_option_scan_and_reply.sv
// Top level of the DHCP option scan and reply block.
// Holds the registers, pool counter, reply decision and result buffer.
// Depends on dosr_pkg and dosr_parser.
//
// Usage:
//   A packet enters on the req channel as one header transaction (action 0,
//   op_code, client_ip) followed by its option-area bytes (action 1),
//   cookie included, the final byte flagged by last_byte. Each transaction is
//   taken when req_valid is high and req_stall low; one transaction per cycle.
//   The final byte yields exactly one result on the rsp channel: offer, ack or
//   no reply. The result is registered, in the output register or the skid.
//   Every per-byte update is one small phase step in the parser, so the block
//   sustains one transaction per clock cycle while req_stall is low.
//   A two-entry result buffer (output register plus skid) lets input flow on
//   while a result waits; req_stall rises only while the skid entry is full,
//   that is after the receiver has held rsp_stall with two results pending.
//   Reset (rst_n low, asynchronous) empties the buffer, restarts the parser,
//   sets the pool to 120..150 and the pool counter to 120, server address 0.
//   The user must write registers through the APB port only while idle; the block does not enforce it.
module dhcp_option_scan_and_reply #(
    parameter int OPTION_AREA_BYTES = dosr_pkg::OPTION_AREA_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  dosr_pkg::req_t              req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output dosr_pkg::rsp_t              rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dosr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [31:0]     server_reg;
    logic [7:0]      pool_first_reg;
    logic [7:0]      pool_last_reg;
    logic [8:0]      next_host_reg;
    logic            out_valid_reg, skid_valid_reg;
    dosr_pkg::rsp_t  out_reg, skid_reg;
    dosr_pkg::rsp_t  result;
    dosr_pkg::scan_t scan;
    logic            take, res_fire, out_take, cfg_wr, hit, offer;
    logic [1:0]      cfg_idx;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[3:2];
    assign req_stall = skid_valid_reg;
    assign take      = req_valid && !req_stall;
    assign res_fire  = take && req.action == dosr_pkg::ACT_OPTION && req.last_byte;
    assign out_take  = out_valid_reg && !rsp_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        case (cfg_idx)
            dosr_pkg::REG_SERVER:     prdata = server_reg;
            dosr_pkg::REG_POOL_FIRST: prdata = {24'd0, pool_first_reg};
            dosr_pkg::REG_POOL_LAST:  prdata = {24'd0, pool_last_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    dosr_parser #(
        .OPTION_AREA_BYTES(OPTION_AREA_BYTES)
    ) u_parser (
        .clk  (clk),
        .rst_n(rst_n),
        .take (take),
        .item (req),
        .scan (scan)
    );

    always_comb
    begin
        hit = scan.held_op == dosr_pkg::BOOTP_REQUEST
            && next_host_reg <= {1'b0, pool_last_reg} && scan.found;
        offer = 1'b0;
        result.reply_kind   = dosr_pkg::KIND_NONE;
        result.your_address = 32'd0;
        result.reply_server = 32'd0;
        if (hit && scan.found_type == dosr_pkg::MSG_DISCOVER)
        begin
            offer = 1'b1;
            result.reply_kind   = dosr_pkg::KIND_OFFER;
            result.your_address = (server_reg & dosr_pkg::NET_MASK)
                                | {next_host_reg[7:0], 24'd0};
            result.reply_server = server_reg;
        end
        else if (hit && scan.found_type == dosr_pkg::MSG_REQUEST)
        begin
            result.reply_kind   = dosr_pkg::KIND_ACK;
            result.your_address = scan.held_client;
            result.reply_server = server_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_reg     <= 32'd0;
            pool_first_reg <= dosr_pkg::POOL_FIRST_RST;
            pool_last_reg  <= dosr_pkg::POOL_LAST_RST;
            next_host_reg  <= {1'b0, dosr_pkg::POOL_FIRST_RST};
        end
        else
        begin
            if (cfg_wr && cfg_idx == dosr_pkg::REG_SERVER)
                server_reg <= pwdata;
            if (cfg_wr && cfg_idx == dosr_pkg::REG_POOL_LAST)
                pool_last_reg <= pwdata[7:0];
            if (cfg_wr && cfg_idx == dosr_pkg::REG_POOL_FIRST)
            begin
                pool_first_reg <= pwdata[7:0];
                next_host_reg  <= {1'b0, pwdata[7:0]};
            end
            else if (res_fire && offer && next_host_reg < dosr_pkg::HOST_SAT)
            begin
                next_host_reg <= next_host_reg + 9'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
                skid_valid_reg <= 1'b0;
        end
        else if (res_fire)
        begin
            if (!out_valid_reg || out_take)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_reg <= skid_reg;
        end
        else if (res_fire)
        begin
            if (!out_valid_reg || out_take)
                out_reg <= result;
            else
                skid_reg <= result;
        end
    end

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output entry");

    a_offer_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (res_fire && offer && !cfg_wr) |=> next_host_reg == $past(next_host_reg) + 9'd1)
        else $error("pool counter did not advance after an offer");

    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.reply_kind == dosr_pkg::KIND_NONE)
        |-> (rsp.your_address == 32'd0 && rsp.reply_server == 32'd0))
        else $error("no-reply result carries address data");

    a_host_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        next_host_reg <= dosr_pkg::HOST_SAT)
        else $error("pool counter beyond saturation");
`endif

endmodule

// File: rtl/dosr_parser.sv
// Option-area walker of the DHCP option scan and reply block.
// Tracks cookie, TLV phase, position and message type per packet; holds the header's op code and client address.
// Depends on dosr_pkg.
module dosr_parser #(
    parameter int OPTION_AREA_BYTES = dosr_pkg::OPTION_AREA_BYTES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  dosr_pkg::req_t  item,
    output dosr_pkg::scan_t scan
);

    localparam int POS_W = $clog2(OPTION_AREA_BYTES + 1);
    localparam logic [POS_W-1:0] POS_LIMIT   = POS_W'(OPTION_AREA_BYTES);
    localparam logic [POS_W-1:0] COOKIE_LAST = POS_W'(3);

    localparam logic [2:0] PH_COOKIE = 3'd0;
    localparam logic [2:0] PH_CODE   = 3'd1;
    localparam logic [2:0] PH_LEN    = 3'd2;
    localparam logic [2:0] PH_SKIP   = 3'd3;
    localparam logic [2:0] PH_TLEN   = 3'd4;
    localparam logic [2:0] PH_TVAL   = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    logic [2:0]       phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       skip_reg, skip_next;
    logic [7:0]       type_reg, type_next;
    logic             found_reg, found_next;
    logic [7:0]       held_op_reg;
    logic [31:0]      held_client_reg;
    logic [7:0]       skip_dec;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        skip_next  = skip_reg;
        type_next  = type_reg;
        found_next = found_reg;
        skip_dec   = (skip_reg != 8'd0) ? skip_reg - 8'd1 : skip_reg;
        if (pos_reg >= POS_LIMIT)
        begin
            phase_next = PH_DONE;
        end
        else
        begin
            pos_next = pos_reg + POS_W'(1);
            case (phase_reg)
                PH_COOKIE:
                begin
                    if (pos_reg >= COOKIE_LAST)
                        phase_next = PH_CODE;
                end
                PH_CODE:
                begin
                    if (item.option_byte == dosr_pkg::OPT_MSG_TYPE)
                        phase_next = PH_TLEN;
                    else if (item.option_byte == dosr_pkg::OPT_END)
                        phase_next = PH_DONE;
                    else if (item.option_byte != dosr_pkg::OPT_PAD)
                        phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    skip_next  = item.option_byte;
                    phase_next = (item.option_byte == 8'd0) ? PH_CODE : PH_SKIP;
                end
                PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 8'd0)
                        phase_next = PH_CODE;
                end
                PH_TLEN:
                begin
                    phase_next = PH_TVAL;
                end
                PH_TVAL:
                begin
                    type_next  = item.option_byte;
                    found_next = 1'b1;
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    assign scan.found       = found_next;
    assign scan.found_type  = type_next;
    assign scan.held_op     = held_op_reg;
    assign scan.held_client = held_client_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_COOKIE;
            pos_reg         <= '0;
            skip_reg        <= '0;
            type_reg        <= '0;
            found_reg       <= 1'b0;
            held_op_reg     <= '0;
            held_client_reg <= '0;
        end
        else if (take)
        begin
            if (item.action == dosr_pkg::ACT_HEADER || item.last_byte)
            begin
                phase_reg <= PH_COOKIE;
                pos_reg   <= '0;
                skip_reg  <= '0;
                type_reg  <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                skip_reg  <= skip_next;
                type_reg  <= type_next;
                found_reg <= found_next;
            end
            if (item.action == dosr_pkg::ACT_HEADER)
            begin
                held_op_reg     <= item.op_code;
                held_client_reg <= item.client_ip;
            end
        end
    end

endmodule

// File: tb/dhcp_option_scan_and_reply_tb.sv
`timescale 1ns / 100ps
// Testbench for dhcp_option_scan_and_reply: directed and random DHCP packets
// checked against a cycle-free predictor of the option scan and reply decision.
// Depends on dosr_pkg and the dhcp_option_scan_and_reply RTL.
module dhcp_option_scan_and_reply_tb;

    localparam int AREA_LIMIT = dosr_pkg::OPTION_AREA_BYTES_DEF;

    typedef enum logic [2:0] {
        SCAN_COOKIE,
        SCAN_CODE,
        SCAN_LEN,
        SCAN_SKIP,
        SCAN_TLEN,
        SCAN_TVAL,
        SCAN_DONE
    } scan_phase_t;

    logic                        clk;
    logic                        rst_n     = 1'b0;
    logic                        req_valid = 1'b0;
    logic                        req_stall;
    dosr_pkg::req_t              req       = '0;
    logic                        rsp_valid;
    logic                        rsp_stall = 1'b0;
    dosr_pkg::rsp_t              rsp;
    logic                        psel      = 1'b0;
    logic                        penable   = 1'b0;
    logic                        pwrite    = 1'b0;
    logic [dosr_pkg::ADDR_W-1:0] paddr     = '0;
    logic [31:0]                 pwdata    = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    dosr_pkg::req_t pending_items[$];
    dosr_pkg::rsp_t expected_replies[$];
    logic [7:0]     packet_bytes[$];

    int             fail_count    = 0;
    int             queued_items  = 0;
    int             queued_pkts   = 0;
    int             send_idle     = 0;
    int             recv_idle     = 0;
    logic           sender_hold   = 1'b0;
    logic           quiet         = 1'b0;
    dosr_pkg::rsp_t reply_want;

    logic [31:0] cfg_server;
    logic [7:0]  cfg_pool_last;
    scan_phase_t scan_phase;
    int          scan_pos;
    logic [7:0]  skip_count;
    logic [7:0]  seen_type;
    logic        type_seen;
    logic [7:0]  latched_op;
    logic [31:0] latched_client;
    logic [8:0]  host_next;

    dhcp_option_scan_and_reply dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("** dhcp_option_scan_and_reply: FAILED **");
        $finish;
    end

    task automatic restart_scan();
        scan_phase = SCAN_COOKIE;
        scan_pos   = 0;
        skip_count = '0;
        seen_type  = '0;
        type_seen  = 1'b0;
    endtask

    task automatic advance_scan(input logic [7:0] b);
        if (scan_pos >= AREA_LIMIT)
        begin
            scan_phase = SCAN_DONE;
        end
        else
        begin
            case (scan_phase)
                SCAN_COOKIE:
                    if (scan_pos >= 3)
                        scan_phase = SCAN_CODE;
                SCAN_CODE:
                    if (b == dosr_pkg::OPT_MSG_TYPE)
                        scan_phase = SCAN_TLEN;
                    else if (b == dosr_pkg::OPT_END)
                        scan_phase = SCAN_DONE;
                    else if (b != dosr_pkg::OPT_PAD)
                        scan_phase = SCAN_LEN;
                SCAN_LEN:
                begin
                    skip_count = b;
                    scan_phase = (b == 8'd0) ? SCAN_CODE : SCAN_SKIP;
                end
                SCAN_SKIP:
                begin
                    if (skip_count != 8'd0)
                        skip_count = skip_count - 8'd1;
                    if (skip_count == 8'd0)
                        scan_phase = SCAN_CODE;
                end
                SCAN_TLEN:
                    scan_phase = SCAN_TVAL;
                SCAN_TVAL:
                begin
                    seen_type  = b;
                    type_seen  = 1'b1;
                    scan_phase = SCAN_DONE;
                end
                default:
                    scan_phase = SCAN_DONE;
            endcase
            scan_pos++;
        end
    endtask

    task automatic predict_reply(input dosr_pkg::req_t t);
        dosr_pkg::rsp_t r;
        r = '0;
        if (t.action == dosr_pkg::ACT_HEADER)
        begin
            latched_op     = t.op_code;
            latched_client = t.client_ip;
            restart_scan();
        end
        else
        begin
            advance_scan(t.option_byte);
            if (t.last_byte)
            begin
                if (latched_op == dosr_pkg::BOOTP_REQUEST
                    && host_next <= {1'b0, cfg_pool_last} && type_seen)
                begin
                    if (seen_type == dosr_pkg::MSG_DISCOVER)
                    begin
                        r.reply_kind   = dosr_pkg::KIND_OFFER;
                        r.your_address = (cfg_server & dosr_pkg::NET_MASK)
                                       | {host_next[7:0], 24'h0};
                        r.reply_server = cfg_server;
                        if (host_next < dosr_pkg::HOST_SAT)
                            host_next = host_next + 9'd1;
                    end
                    else if (seen_type == dosr_pkg::MSG_REQUEST)
                    begin
                        r.reply_kind   = dosr_pkg::KIND_ACK;
                        r.your_address = latched_client;
                        r.reply_server = cfg_server;
                    end
                end
                restart_scan();
                expected_replies.push_back(r);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
                predict_reply(req);
            if (!req_valid || !req_stall)
            begin
                if (send_idle != 0)
                begin
                    send_idle--;
                    req_valid <= 1'b0;
                end
                else if (pending_items.size() != 0 && !sender_hold)
                begin
                    if (!quiet && $urandom_range(0, 7) == 0)
                    begin
                        send_idle = $urandom_range(0, 10);
                        req_valid <= 1'b0;
                    end
                    else
                    begin
                        req       <= pending_items.pop_front();
                        req_valid <= 1'b1;
                    end
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: reply with none expected: kind %0d yiaddr %h siaddr %h",
                             $time, rsp.reply_kind, rsp.your_address, rsp.reply_server);
                    fail_count++;
                end
                else
                begin
                    reply_want = expected_replies.pop_front();
                    if (rsp !== reply_want)
                    begin
                        $display("%0t: mismatch: expected %0d %h %h, got %0d %h %h",
                                 $time, reply_want.reply_kind, reply_want.your_address,
                                 reply_want.reply_server, rsp.reply_kind,
                                 rsp.your_address, rsp.reply_server);
                        fail_count++;
                    end
                end
            end
            if (recv_idle != 0)
            begin
                recv_idle--;
                rsp_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                recv_idle = $urandom_range(0, 10);
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    function automatic dosr_pkg::req_t rand_item(input logic act);
        dosr_pkg::req_t t;
        t.action      = act;
        t.op_code     = 8'($urandom);
        t.client_ip   = $urandom;
        t.option_byte = 8'($urandom);
        t.last_byte   = 1'($urandom_range(0, 1));
        return t;
    endfunction

    task automatic push_header(input logic [7:0] op, input logic [31:0] client,
                               input logic last);
        dosr_pkg::req_t t;
        t           = rand_item(dosr_pkg::ACT_HEADER);
        t.op_code   = op;
        t.client_ip = client;
        t.last_byte = last;
        pending_items.push_back(t);
        queued_items++;
    endtask

    task automatic flush_packet();
        dosr_pkg::req_t t;
        foreach (packet_bytes[i])
        begin
            t             = rand_item(dosr_pkg::ACT_OPTION);
            t.option_byte = packet_bytes[i];
            t.last_byte   = (i == packet_bytes.size() - 1);
            pending_items.push_back(t);
            queued_items++;
        end
        packet_bytes.delete();
        queued_pkts++;
    endtask

    task automatic push_cookie();
        repeat (4) packet_bytes.push_back(8'($urandom));
    endtask

    task automatic queue_random_packet();
        logic [7:0] code;
        int         len;
        if ($urandom_range(0, 19) != 0)
            push_header(($urandom_range(0, 9) == 0) ? 8'($urandom) : dosr_pkg::BOOTP_REQUEST,
                        $urandom, 1'($urandom_range(0, 1)));
        push_cookie();
        repeat ($urandom_range(0, 3))
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                packet_bytes.push_back(dosr_pkg::OPT_PAD);
            end
            else
            begin
                do
                    code = 8'($urandom);
                while (code == dosr_pkg::OPT_PAD || code == dosr_pkg::OPT_MSG_TYPE
                       || code == dosr_pkg::OPT_END);
                len = $urandom_range(0, 6);
                packet_bytes.push_back(code);
                packet_bytes.push_back(8'(len));
                repeat (len) packet_bytes.push_back(8'($urandom));
            end
        end
        if ($urandom_range(0, 9) != 0)
        begin
            packet_bytes.push_back(dosr_pkg::OPT_MSG_TYPE);
            packet_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd1);
            case ($urandom_range(0, 4))
                0, 1:    packet_bytes.push_back(dosr_pkg::MSG_DISCOVER);
                2, 3:    packet_bytes.push_back(dosr_pkg::MSG_REQUEST);
                default: packet_bytes.push_back(8'($urandom));
            endcase
        end
        else if ($urandom_range(0, 1) == 1)
        begin
            packet_bytes.push_back(dosr_pkg::OPT_END);
        end
        repeat ($urandom_range(0, 2))
            packet_bytes.push_back(($urandom_range(0, 1) == 1) ? dosr_pkg::OPT_END
                                                               : 8'($urandom));
        if (packet_bytes.size() == 0)
            packet_bytes.push_back(8'($urandom));
        flush_packet();
    endtask

    task automatic queue_noise();
        dosr_pkg::req_t t;
        repeat ($urandom_range(1, 12))
        begin
            t = rand_item(1'($urandom_range(0, 1)));
            pending_items.push_back(t);
            queued_items++;
        end
        packet_bytes.push_back(8'($urandom));
        flush_packet();
    endtask

    // Place the type option across the end of the option area by the second filler length.
    task automatic queue_long_packet(input int filler_len);
        push_header(dosr_pkg::BOOTP_REQUEST, $urandom, 1'b0);
        push_cookie();
        packet_bytes.push_back(8'd7);
        packet_bytes.push_back(8'd255);
        repeat (255) packet_bytes.push_back(8'($urandom));
        packet_bytes.push_back(8'd8);
        packet_bytes.push_back(8'(filler_len));
        repeat (filler_len) packet_bytes.push_back(8'($urandom));
        packet_bytes.push_back(dosr_pkg::OPT_MSG_TYPE);
        packet_bytes.push_back(8'd1);
        packet_bytes.push_back(($urandom_range(0, 1) == 1) ? dosr_pkg::MSG_DISCOVER
                                                           : dosr_pkg::MSG_REQUEST);
        repeat (6) packet_bytes.push_back(8'($urandom));
        flush_packet();
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            dosr_pkg::REG_SERVER:
                cfg_server = value;
            dosr_pkg::REG_POOL_FIRST:
                host_next = {1'b0, value[7:0]};
            dosr_pkg::REG_POOL_LAST:
                cfg_pool_last = value[7:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || req_valid || expected_replies.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic run_phase(input logic [31:0] server, input logic [7:0] first,
                             input logic [7:0] last, input int n_items, input int n_pkts,
                             input bit with_long, input bit with_pause);
        write_reg(dosr_pkg::REG_SERVER, server);
        write_reg(dosr_pkg::REG_POOL_LAST, {24'h0, last});
        write_reg(dosr_pkg::REG_POOL_FIRST, {24'h0, first});
        @(negedge clk);
        queued_items = 0;
        queued_pkts  = 0;
        if (with_long)
            queue_long_packet(46 + int'($urandom_range(0, 1)));
        while (queued_items < n_items || queued_pkts < n_pkts)
        begin
            if ($urandom_range(0, 6) == 0)
                queue_noise();
            else
                queue_random_packet();
        end
        if (with_pause)
        begin
            while (pending_items.size() > queued_items / 2)
                @(negedge clk);
            sender_hold = 1'b1;
            while (req_valid || expected_replies.size() != 0)
                @(negedge clk);
            sender_hold = 1'b0;
        end
        wait_idle();
    endtask

    initial
    begin
        cfg_server     = '0;
        cfg_pool_last  = dosr_pkg::POOL_LAST_RST;
        latched_op     = '0;
        latched_client = '0;
        host_next      = {1'b0, dosr_pkg::POOL_FIRST_RST};
        restart_scan();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_header(dosr_pkg::BOOTP_REQUEST, 32'hFFFF_FFFF, 1'b0);
        packet_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, dosr_pkg::OPT_MSG_TYPE, 8'd1,
                         dosr_pkg::MSG_DISCOVER};
        flush_packet();
        push_header(dosr_pkg::BOOTP_REQUEST, 32'h0000_0000, 1'b0);
        packet_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, dosr_pkg::OPT_PAD, 8'd12, 8'd0,
                         8'd61, 8'd2, dosr_pkg::OPT_MSG_TYPE, dosr_pkg::OPT_END,
                         dosr_pkg::OPT_MSG_TYPE, 8'd1, dosr_pkg::MSG_REQUEST};
        flush_packet();
        push_header(8'hFF, 32'h1234_5678, 1'b0);
        packet_bytes = '{8'h63, 8'h82, 8'h53, 8'h63, dosr_pkg::OPT_MSG_TYPE, 8'd1,
                         dosr_pkg::MSG_DISCOVER};
        flush_packet();
        push_header(dosr_pkg::BOOTP_REQUEST, 32'hC0A8_0105, 1'b1);
        packet_bytes = '{8'h63, 8'h82, 8'h53, 8'h63, dosr_pkg::OPT_END,
                         dosr_pkg::OPT_MSG_TYPE, 8'd1, dosr_pkg::MSG_DISCOVER};
        flush_packet();
        packet_bytes = '{8'h63, 8'h82, 8'h53, 8'h63, dosr_pkg::OPT_MSG_TYPE, 8'd1, 8'd5};
        flush_packet();
        packet_bytes = '{8'h63, 8'h82, 8'h53, 8'h63, dosr_pkg::OPT_MSG_TYPE, 8'd1,
                         dosr_pkg::MSG_DISCOVER};
        flush_packet();
        push_header(dosr_pkg::BOOTP_REQUEST, 32'h0A00_0001, 1'b0);
        packet_bytes = '{8'h63, 8'h82, 8'h53, 8'h63, 8'd3, 8'd1, 8'd7};
        flush_packet();
        push_header(dosr_pkg::BOOTP_REQUEST, 32'h0A00_0002, 1'b0);
        packet_bytes = '{8'h63};
        flush_packet();
        wait_idle();

        run_phase($urandom, dosr_pkg::POOL_FIRST_RST, dosr_pkg::POOL_LAST_RST, 0, 1,
                  1'b1, 1'b1);
        run_phase(32'hFFFF_FFFF, 8'd254, 8'd255, 0, 3, 1'b0, 1'b0);
        run_phase(32'h0000_0000, 8'd0, 8'd0, 0, 1, 1'b0, 1'b0);
        run_phase($urandom, 8'd255, 8'd0, 0, 1, 1'b0, 1'b0);
        quiet = 1'b1;
        run_phase($urandom, 8'd10, 8'd60, 0, 2, 1'b0, 1'b1);

        if (fail_count == 0)
            $display("** dhcp_option_scan_and_reply: PASSED **");
        else
            $display("** dhcp_option_scan_and_reply: FAILED **");
        $finish;
    end

endmodule
